>>> sv/hcl_pkg.sv
// Shared constants and types of the RGB / hue-chroma-luma converter.
package hcl_pkg;

  localparam int NStg      = 7;
  localparam int HueSector = 3840;
  localparam int HueFull   = 23040;
  localparam int DivStg    = 5;
  localparam int DivStep   = 3;
  localparam int QW        = DivStg * DivStep;

  localparam logic DirFwd = 1'b0;
  localparam logic DirRev = 1'b1;

  localparam logic RegDirection = 1'b0;

  typedef logic [NStg-1:0] stage_en_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] chroma;
    logic [12:0] luma;
  } hcl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

>>> sv/hcl_fwd.sv
// Forward path: RGB bytes to hue, chroma and Rec.601 luma.
module hcl_fwd import hcl_pkg::*; (
  input  logic       clk,
  input  stage_en_t  en,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output hcl_t       res
);

  localparam logic [26:0] LumaRecip = 27'((64'd1 << 41) / 31875);

  logic [7:0] r_r, g_r, b_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r <= red_in;
      g_r <= green_in;
      b_r <= blue_in;
    end
  end

  // stage 2: extremes, hue numerator, weighted sum, chroma
  logic [7:0]         mx, mn, dd;
  logic [1:0]         which;
  logic signed [8:0]  sd;
  logic [2:0]         kk;
  logic signed [24:0] num_s;
  logic [17:0]        wsum;
  logic [11:0]        d16;
  logic [12:0]        t1, t2, chroma_c;

  always_comb begin
    mx = r_r;
    mn = r_r;
    which = 2'd0;
    if (g_r < mn) mn = g_r;
    if (b_r < mn) mn = b_r;
    if (g_r > mx) begin
      mx = g_r;
      which = 2'd1;
    end
    if (b_r > mx) begin
      mx = b_r;
      which = 2'd2;
    end
    dd = mx - mn;
    unique case (which)
      2'd1: begin
        sd = $signed({1'b0, b_r}) - $signed({1'b0, r_r});
        kk = 3'd2;
      end
      2'd2: begin
        sd = $signed({1'b0, r_r}) - $signed({1'b0, g_r});
        kk = 3'd4;
      end
      default: begin
        sd = $signed({1'b0, g_r}) - $signed({1'b0, b_r});
        kk = 3'd0;
      end
    endcase
    num_s = $signed(25'(HueSector)) * 25'(sd)
          + $signed({2'b00, 23'(kk) * 23'(HueSector) * 23'(dd)});
    if (num_s < 0) num_s = num_s + $signed({2'b00, 23'(HueFull) * 23'(dd)});
    wsum = 18'(299) * 18'(r_r) + 18'(587) * 18'(g_r) + 18'(114) * 18'(b_r);
    // chroma = 16d + floor(16d / 255)
    d16 = {dd, 4'b0000};
    t1 = 13'(d16) + 13'd1;
    t2 = t1 + (t1 >> 8);
    chroma_c = 13'(d16) + (t2 >> 8);
  end

  logic [22:0] num_r;
  logic [7:0]  d2_r;
  logic        gray2_r;
  logic [17:0] wsum2_r;
  logic [12:0] chroma2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_r     <= num_s[22:0];
      d2_r      <= dd;
      gray2_r   <= (dd == 8'd0);
      wsum2_r   <= wsum;
      chroma2_r <= chroma_c;
    end
  end

  // restoring divider, DivStep quotient bits per stage
  logic [7:0]    rem_r  [DivStg];
  logic [QW-1:0] lo_r   [DivStg];
  logic [QW-1:0] q_r    [DivStg];
  logic [7:0]    dv_r   [DivStg];
  logic          gray_r [DivStg];
  logic [12:0]   ch_r   [DivStg];

  for (genvar j = 0; j < DivStg; j++) begin : g_div
    logic [7:0]    rem_i, d_i, rem_nxt;
    logic [QW-1:0] lo_i, q_i, lo_nxt, q_nxt;
    logic          gray_i;
    logic [12:0]   ch_i;
    logic [8:0]    t;

    if (j == 0) begin : g_first
      assign rem_i  = num_r[22:QW];
      assign lo_i   = num_r[QW-1:0];
      assign q_i    = '0;
      assign d_i    = d2_r;
      assign gray_i = gray2_r;
      assign ch_i   = chroma2_r;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign lo_i   = lo_r[j-1];
      assign q_i    = q_r[j-1];
      assign d_i    = dv_r[j-1];
      assign gray_i = gray_r[j-1];
      assign ch_i   = ch_r[j-1];
    end

    always_comb begin
      rem_nxt = rem_i;
      lo_nxt  = lo_i;
      q_nxt   = q_i;
      t       = '0;
      for (int s = 0; s < DivStep; s++) begin
        t = {rem_nxt, lo_nxt[QW-1]};
        lo_nxt = {lo_nxt[QW-2:0], 1'b0};
        if (t >= {1'b0, d_i}) begin
          rem_nxt = 8'(t - {1'b0, d_i});
          q_nxt = {q_nxt[QW-2:0], 1'b1};
        end else begin
          rem_nxt = t[7:0];
          q_nxt = {q_nxt[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        rem_r[j]  <= rem_nxt;
        lo_r[j]   <= lo_nxt;
        q_r[j]    <= q_nxt;
        dv_r[j]   <= d_i;
        gray_r[j] <= gray_i;
        ch_r[j]   <= ch_i;
      end
    end
  end

  // luma = floor(S * 512 / 31875) by reciprocal and one correction
  logic [44:0] lprod3_r;
  logic [17:0] wsum3_r;
  logic [12:0] lest4_r;
  logic [27:0] lrem4_r;
  logic [12:0] luma5_r, luma6_r, luma7_r;
  logic [12:0] lest;

  assign lest = lprod3_r[44:32];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lprod3_r <= 45'(wsum2_r) * 45'(LumaRecip);
      wsum3_r  <= wsum2_r;
    end
    if (en[3]) begin
      lest4_r <= lest;
      lrem4_r <= 28'({wsum3_r, 9'b0}) - 28'(lest) * 28'(31875);
    end
    if (en[4]) luma5_r <= lest4_r + 13'(lrem4_r >= 28'd31875);
    if (en[5]) luma6_r <= luma5_r;
    if (en[6]) luma7_r <= luma6_r;
  end

  assign res.hue    = gray_r[DivStg-1] ? '0 : q_r[DivStg-1];
  assign res.chroma = ch_r[DivStg-1];
  assign res.luma   = luma7_r;

endmodule

>>> sv/hcl_rev.sv
// Reverse path: hue, chroma and luma back to saturated RGB bytes.
module hcl_rev import hcl_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [14:0] hue_in,
  input  logic [12:0] chroma_in,
  input  logic [12:0] luma_in,
  output rgb_t        res
);

  localparam logic [21:0] RevRecip = 22'((64'd1 << 32) / 1875);
  localparam logic [20:0] SatLimit = 21'd480000;

  logic [14:0] h_r;
  logic [12:0] c_r, l_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h_r <= hue_in;
      c_r <= chroma_in;
      l_r <= luma_in;
    end
  end

  // stage 2: wrap, sector, distance from the middle of the sector pair, gray value
  logic [14:0] hw, f, hdist;
  logic [2:0]  sec;
  logic [20:0] gtmp;
  logic [7:0]  gv;

  always_comb begin
    hw = (h_r >= 15'(HueFull)) ? h_r - 15'(HueFull) : h_r;
    priority if (hw >= 15'(5 * HueSector)) sec = 3'd5;
    else if (hw >= 15'(4 * HueSector)) sec = 3'd4;
    else if (hw >= 15'(3 * HueSector)) sec = 3'd3;
    else if (hw >= 15'(2 * HueSector)) sec = 3'd2;
    else if (hw >= 15'(HueSector))     sec = 3'd1;
    else                               sec = 3'd0;
    f = hw - 15'(2 * HueSector) * 15'(sec[2:1]);
    hdist = (f >= 15'(HueSector)) ? f - 15'(HueSector) : 15'(HueSector) - f;
    gtmp = 21'(l_r) * 21'(255);
    gv = (gtmp[20:12] > 9'd255) ? 8'd255 : gtmp[19:12];
  end

  logic [2:0]  sec2_r;
  logic [11:0] xm2_r;
  logic [12:0] c2_r, l2_r;
  logic        gray2_r, gray3_r, gray4_r, gray5_r, gray6_r;
  logic [7:0]  gv2_r, gv3_r, gv4_r, gv5_r, gv6_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2_r  <= sec;
      xm2_r   <= 12'(15'(HueSector) - hdist);
      c2_r    <= c_r;
      l2_r    <= l_r;
      gray2_r <= (c_r == 13'd0);
      gv2_r   <= gv;
    end
  end

  // stage 3: scaled channel values of the sector
  logic [24:0] cs, xs;
  logic [24:0] ch_c [3];

  always_comb begin
    cs = 25'(c2_r) * 25'(HueSector);
    xs = 25'(c2_r) * 25'(xm2_r);
    unique case (sec2_r)
      3'd0: begin ch_c[0] = cs; ch_c[1] = xs; ch_c[2] = '0; end
      3'd1: begin ch_c[0] = xs; ch_c[1] = cs; ch_c[2] = '0; end
      3'd2: begin ch_c[0] = '0; ch_c[1] = cs; ch_c[2] = xs; end
      3'd3: begin ch_c[0] = '0; ch_c[1] = xs; ch_c[2] = cs; end
      3'd4: begin ch_c[0] = xs; ch_c[1] = '0; ch_c[2] = cs; end
      default: begin ch_c[0] = cs; ch_c[1] = '0; ch_c[2] = xs; end
    endcase
  end

  logic [24:0] ch3_r [3];
  logic [24:0] ch4_r [3];
  logic [34:0] lterm3_r;
  logic signed [35:0] base4_r;
  logic signed [36:0] v5_r [3];
  logic        pos6_r [3];
  logic        sat6_r [3];
  logic [20:0] w6_r [3];
  logic [42:0] prod6_r [3];
  logic [7:0]  out7_r [3];

  logic [34:0] wsum;
  assign wsum = 35'(299) * 35'(ch3_r[0]) + 35'(587) * 35'(ch3_r[1])
              + 35'(114) * 35'(ch3_r[2]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ch3_r    <= ch_c;
      lterm3_r <= 35'(l2_r) * 35'(3840000);
      gray3_r  <= gray2_r;
      gv3_r    <= gv2_r;
    end
    if (en[3]) begin
      ch4_r   <= ch3_r;
      base4_r <= $signed({1'b0, lterm3_r}) - $signed({1'b0, wsum});
      gray4_r <= gray3_r;
      gv4_r   <= gv3_r;
    end
    if (en[4]) begin
      gray5_r <= gray4_r;
      gv5_r   <= gv4_r;
    end
    if (en[5]) begin
      gray6_r <= gray5_r;
      gv6_r   <= gv5_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [36:0] v_nxt;
    logic signed [44:0] p;
    logic [20:0]        w;
    logic [10:0]        est;
    logic [20:0]        rem;
    logic [8:0]         q;

    assign v_nxt = $signed({2'b00, 35'(ch4_r[k]) * 35'(1000)}) + 37'(base4_r);
    assign p     = (45'(v5_r[k]) <<< 8) - 45'(v5_r[k]);
    assign w     = p[43:23];
    assign est   = prod6_r[k][42:32];
    assign rem   = w6_r[k] - 21'(est) * 21'(1875);
    assign q     = 9'(est) + 9'(rem >= 21'd1875);

    always_ff @(posedge clk) begin
      if (en[4]) v5_r[k] <= v_nxt;
      if (en[5]) begin
        pos6_r[k]  <= (v5_r[k] > 37'sd0);
        sat6_r[k]  <= (w >= SatLimit);
        w6_r[k]    <= w;
        prod6_r[k] <= 43'(w) * 43'(RevRecip);
      end
      if (en[6]) begin
        priority if (gray6_r) out7_r[k] <= gv6_r;
        else if (!pos6_r[k]) out7_r[k] <= '0;
        else if (sat6_r[k]) out7_r[k] <= 8'd255;
        else out7_r[k] <= q[7:0];
      end
    end
  end

  assign res.red   = out7_r[0];
  assign res.green = out7_r[1];
  assign res.blue  = out7_r[2];

endmodule

>>> sv/rgb_hcl_color_converter.sv
// Top level of the pixel converter between RGB bytes and hue / chroma / luma.
//
// One pixel enters per request on the input channel and one result leaves per
// request on the output channel, in order. The block is a seven-stage pipeline
// that accepts a pixel in every cycle while the output side takes every result.
// Each stage has its own valid bit and holds only while the stage below it is
// full and holding, so a stalled output keeps filling the empty stages behind
// it. The forward hue division runs in a restoring divider of five stages with
// three quotient bits each; luma and the reverse channel scaling use constant
// reciprocals with a one-step correction. The direction register (APB address
// 0, bit 0: 0 = RGB to HCL, 1 = HCL to RGB) travels with each pixel; write it
// only while the pipeline is empty. Fields of the unused mode read as zero.
module rgb_hcl_color_converter import hcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [14:0] in_hue_in,
  input  logic [12:0] in_chroma_in,
  input  logic [12:0] in_luma_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [14:0] out_hue_out,
  output logic [12:0] out_chroma_out,
  output logic [12:0] out_luma_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration: one word register, write on the access phase
  logic direction_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegDirection) ? {31'b0, direction_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DirFwd;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == RegDirection) begin
      direction_r <= cfg_pwdata[0];
    end
  end

  // stage control: a stage loads when it is empty or its successor loads
  logic [NStg-1:0] v_r;
  stage_en_t       en;

  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NStg-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // carry the mode with each pixel
  logic dir_r [NStg];

  always_ff @(posedge clk) begin
    if (en[0]) dir_r[0] <= direction_r;
    for (int k = 1; k < NStg; k++) begin
      if (en[k]) dir_r[k] <= dir_r[k-1];
    end
  end

  hcl_t fwd_res;
  rgb_t rev_res;

  hcl_fwd u_fwd (
    .clk      (clk),
    .en       (en),
    .red_in   (in_red_in),
    .green_in (in_green_in),
    .blue_in  (in_blue_in),
    .res      (fwd_res)
  );

  hcl_rev u_rev (
    .clk       (clk),
    .en        (en),
    .hue_in    (in_hue_in),
    .chroma_in (in_chroma_in),
    .luma_in   (in_luma_in),
    .res       (rev_res)
  );

  // zero the fields of the mode not in use
  logic is_rev;
  assign is_rev = (dir_r[NStg-1] == DirRev);

  assign out_red_out    = is_rev ? rev_res.red   : '0;
  assign out_green_out  = is_rev ? rev_res.green : '0;
  assign out_blue_out   = is_rev ? rev_res.blue  : '0;
  assign out_hue_out    = is_rev ? '0 : fwd_res.hue;
  assign out_chroma_out = is_rev ? '0 : fwd_res.chroma;
  assign out_luma_out   = is_rev ? '0 : fwd_res.luma;

  // input side blocks only when the first stage holds a pixel
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0])
    else $error("input blocked with empty first stage");

  // an accepted pixel lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted pixel lost at entry");

  // a held output stage keeps its mode
  a_hold_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(dir_r[NStg-1]))
    else $error("mode changed under a stalled result");

  // forward results stay within their ranges
  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !is_rev) |->
      (out_hue_out < 15'd23040 && out_chroma_out <= 13'd4096
       && out_luma_out <= 13'd4096))
    else $error("forward result out of range");

endmodule
